// ----- design/qmn_pkg.sv -----
// Shared constants, types and helpers for the quaternion multiply-normalise unit.
package qmn_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int IN_W   = 16;
	localparam int PROD_W = 34;
	localparam int MAG_W  = 33;
	localparam int LEAD_W = 6;
	localparam int M_W    = 30;
	localparam int M_TOP  = M_W - 1;
	localparam int SQ_W   = 2 * M_W;
	localparam int S_W    = SQ_W + 2;
	localparam int ROOT_W = S_W / 2;
	localparam int SQ_REM_W = ROOT_W + 2;

	// b operand chosen for each term of each product component (a index is the term)
	localparam int BSEL [4][4] = '{
		'{0, 1, 2, 3},
		'{1, 0, 3, 2},
		'{2, 3, 0, 1},
		'{3, 2, 1, 0}
	};
	// terms subtracted, bit t for term t
	localparam logic [3:0] TNEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

	typedef struct packed {
		logic [3:0][M_W-1:0] m;
		logic [3:0]          neg;
		logic                zero;
	} qmn_side_t;

	function automatic logic [15:0] sat16(input logic signed [63:0] v);
		logic [15:0] r;
		if (v > 64'sd32767) begin
			r = 16'h7fff;
		end else if (v < -64'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ----- design/quaternion_multiply_normalize_unit.sv -----
// Top level: Hamilton product of two Q1.14 quaternions, normalised to unit length.
//
//  port group | dir | word contents (lowest bit first)
//  s_t*       | in  | a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (16 b each)
//  m_t*       | out | tdata p_w, p_x, p_y, p_z (16 b each); tuser degenerate
//
// One word in and one out per cycle while the output is not stalled; the path is
// 7 product/normalise stages, 31 root stages, FRAC_BITS + 2 divide stages, output register.
// The root pipeline and the four divider lanes each resolve one bit per stage.
// Reset clears the valid bits only. A stall at the output freezes every stage together.
module quaternion_multiply_normalize_unit #(
	parameter int FRAC_BITS = qmn_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // p_w, p_x, p_y, p_z
	output logic [0:0]   m_tuser    // degenerate
);

	localparam int IW = qmn_pkg::IN_W;
	localparam int PW = qmn_pkg::PROD_W;
	localparam int MG = qmn_pkg::MAG_W;
	localparam int LW = qmn_pkg::LEAD_W;
	localparam int MW = qmn_pkg::M_W;
	localparam int QW = qmn_pkg::SQ_W;
	localparam int SW = qmn_pkg::S_W;

	logic en;
	logic out_vld_q;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_vld_q;

	// s1: sixteen signed products
	logic signed [IW-1:0] a [4];
	logic signed [IW-1:0] b [4];
	logic                         v_s1;
	logic signed [2*IW-1:0]       t_s1 [4][4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a[i] = s_tdata[IW*i +: IW];
			b[i] = s_tdata[4*IW + IW*i +: IW];
		end
	end

	// s2: component sums
	logic                  v_s2;
	logic signed [PW-1:0]  p_s2 [4];
	// s3: magnitudes
	logic                  v_s3;
	logic [MG-1:0]         mag_s3 [4];
	logic [3:0]            neg_s3;
	// s4: leading one
	logic                  v_s4;
	logic [MG-1:0]         mag_s4 [4];
	logic [3:0]            neg_s4;
	logic [LW-1:0]         lead_s4;
	logic                  zero_s4;
	// s5: normalised magnitudes
	logic                  v_s5;
	logic [3:0][MW-1:0]    m_s5;
	logic [3:0]            neg_s5;
	logic                  zero_s5;
	// s6: squares
	logic                  v_s6;
	logic [QW-1:0]         sq_s6 [4];
	logic [3:0][MW-1:0]    m_s6;
	logic [3:0]            neg_s6;
	logic                  zero_s6;
	// s7: sum of squares
	logic                  v_s7;
	logic [SW-1:0]         s_s7;
	qmn_pkg::qmn_side_t    side_s7;

	logic [MG-1:0] orv;
	logic [LW-1:0] lead;

	always_comb begin
		orv = mag_s3[0] | mag_s3[1] | mag_s3[2] | mag_s3[3];
		lead = '0;
		for (int i = 0; i < MG; i++) begin
			if (orv[i]) begin
				lead = LW'(i);
			end
		end
	end

	logic [3:0][MW-1:0] mnorm;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (lead_s4 > LW'(qmn_pkg::M_TOP)) begin
				mnorm[i] = MW'(mag_s4[i] >> (lead_s4 - LW'(qmn_pkg::M_TOP)));
			end else begin
				mnorm[i] = MW'(mag_s4[i] << (LW'(qmn_pkg::M_TOP) - lead_s4));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				for (int t = 0; t < 4; t++) begin
					t_s1[c][t] <= qmn_pkg::TNEG[c][t] ? -(a[t] * b[qmn_pkg::BSEL[c][t]])
						: a[t] * b[qmn_pkg::BSEL[c][t]];
				end
				p_s2[c] <= PW'(t_s1[c][0]) + PW'(t_s1[c][1]) + PW'(t_s1[c][2])
					+ PW'(t_s1[c][3]);
				mag_s3[c] <= p_s2[c][PW-1] ? MG'(-p_s2[c]) : MG'(p_s2[c]);
				neg_s3[c] <= p_s2[c][PW-1];
				mag_s4[c] <= mag_s3[c];
				sq_s6[c]  <= QW'(m_s5[c]) * QW'(m_s5[c]);
			end
			neg_s4  <= neg_s3;
			lead_s4 <= lead;
			zero_s4 <= orv == '0;
			m_s5    <= mnorm;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			m_s6    <= m_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
			s_s7    <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]) + SW'(sq_s6[3]);
			side_s7.m    <= m_s6;
			side_s7.neg  <= neg_s6;
			side_s7.zero <= zero_s6;
		end
	end

	logic                            rt_vld;
	logic [qmn_pkg::ROOT_W-1:0]      rt_n;
	qmn_pkg::qmn_side_t              rt_side;

	qmn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s7),
		.in_s     (s_s7),
		.in_side  (side_s7),
		.out_vld  (rt_vld),
		.out_root (rt_n),
		.out_side (rt_side)
	);

	logic                       dv_vld;
	logic [3:0][FRAC_BITS:0]    dv_r;
	qmn_pkg::qmn_side_t         dv_side;

	qmn_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (rt_vld),
		.in_n     (rt_n),
		.in_side  (rt_side),
		.out_vld  (dv_vld),
		.out_r    (dv_r),
		.out_side (dv_side)
	);

	logic [3:0][15:0]            res;
	logic signed [FRAC_BITS+1:0] sv [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sv[i] = dv_side.neg[i] ? -$signed({1'b0, dv_r[i]}) : $signed({1'b0, dv_r[i]});
			res[i] = qmn_pkg::sat16(64'(sv[i]));
		end
		if (dv_side.zero) begin
			res[0] = qmn_pkg::sat16(64'(1) << FRAC_BITS);
			res[1] = '0;
			res[2] = '0;
			res[3] = '0;
		end
	end

	logic [63:0] data_q;
	logic        degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q  <= res;
			degen_q <= dv_side.zero;
		end
	end

	assign m_tdata = data_q;
	assign m_tuser = degen_q;

	a_degen_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[63:16] == 48'd0)
		else $error("degenerate word carries a vector part");

	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata != 64'd0)
		else $error("normalised product came out zero");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s7) && $stable(s_s7) && $stable(side_s7))
		else $error("pipeline moved during a stall");

endmodule

// ----- design/qmn_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with sideband carried alongside.
module qmn_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic [qmn_pkg::S_W-1:0]        in_s,
	input  qmn_pkg::qmn_side_t             in_side,
	output logic                           out_vld,
	output logic [qmn_pkg::ROOT_W-1:0]     out_root,
	output qmn_pkg::qmn_side_t             out_side
);

	localparam int N  = qmn_pkg::ROOT_W;
	localparam int RW = qmn_pkg::SQ_REM_W;
	localparam int SW = qmn_pkg::S_W;

	logic                  vld_s  [N];
	logic [RW-1:0]         rem_s  [N];
	logic [N-1:0]          root_s [N];
	logic [SW-1:0]         sv_s   [N];
	qmn_pkg::qmn_side_t    side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic                 src_vld;
		logic [RW-1:0]        src_rem;
		logic [N-1:0]         src_root;
		logic [SW-1:0]        src_s;
		qmn_pkg::qmn_side_t   src_side;
		logic [RW+1:0]        cur;
		logic [RW+1:0]        trial;
		logic                 ge;

		if (k == 0) begin : g_first
			assign src_vld  = in_vld;
			assign src_rem  = '0;
			assign src_root = '0;
			assign src_s    = in_s;
			assign src_side = in_side;
		end else begin : g_next
			assign src_vld  = vld_s[k-1];
			assign src_rem  = rem_s[k-1];
			assign src_root = root_s[k-1];
			assign src_s    = sv_s[k-1];
			assign src_side = side_s[k-1];
		end

		always_comb begin
			cur   = {src_rem, src_s[SW-1-2*k -: 2]};
			trial = {2'b00, src_root, 2'b01};
			ge    = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? RW'(cur - trial) : RW'(cur);
				root_s[k] <= {src_root[N-2:0], ge};
				sv_s[k]   <= src_s;
				side_s[k] <= src_side;
			end
		end
	end

	assign out_vld  = vld_s[N-1];
	assign out_root = root_s[N-1];
	assign out_side = side_s[N-1];

endmodule

// ----- design/qmn_div.sv -----
// Four-lane pipelined restoring divider giving rounded m * 2^FRAC_BITS / n.
module qmn_div #(
	parameter int FRAC_BITS = qmn_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic [qmn_pkg::ROOT_W-1:0]     in_n,
	input  qmn_pkg::qmn_side_t             in_side,
	output logic                           out_vld,
	output logic [3:0][FRAC_BITS:0]        out_r,
	output qmn_pkg::qmn_side_t             out_side
);

	localparam int Q     = FRAC_BITS + 1;
	localparam int MW    = qmn_pkg::M_W;
	localparam int NUM_W = MW + Q + 1;
	localparam int DW    = qmn_pkg::ROOT_W + 1;

	// numerator pre-stage
	logic                  vld_p;
	logic [3:0][DW-1:0]    rem_p;
	logic [3:0][Q-1:0]     low_p;
	logic [DW-1:0]         d_p;
	qmn_pkg::qmn_side_t    side_p;

	logic [3:0][NUM_W-1:0] num;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			num[i] = {1'b0, in_side.m[i], Q'(0)} + NUM_W'(in_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= 1'b0;
		end else if (en) begin
			vld_p <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				rem_p[i] <= DW'(num[i][NUM_W-1:Q]);
				low_p[i] <= num[i][Q-1:0];
			end
			d_p    <= {in_n, 1'b0};
			side_p <= in_side;
		end
	end

	logic                  vld_s  [Q];
	logic [3:0][DW-1:0]    rem_s  [Q];
	logic [3:0][Q-1:0]     low_s  [Q];
	logic [3:0][Q-1:0]     q_s    [Q];
	logic [DW-1:0]         d_s    [Q];
	qmn_pkg::qmn_side_t    side_s [Q];

	for (genvar j = 0; j < Q; j++) begin : g_step
		logic                 src_vld;
		logic [3:0][DW-1:0]   src_rem;
		logic [3:0][Q-1:0]    src_low;
		logic [3:0][Q-1:0]    src_q;
		logic [DW-1:0]        src_d;
		qmn_pkg::qmn_side_t   src_side;
		logic [3:0][DW:0]     cur;
		logic [3:0]           ge;

		if (j == 0) begin : g_first
			assign src_vld  = vld_p;
			assign src_rem  = rem_p;
			assign src_low  = low_p;
			assign src_q    = '0;
			assign src_d    = d_p;
			assign src_side = side_p;
		end else begin : g_next
			assign src_vld  = vld_s[j-1];
			assign src_rem  = rem_s[j-1];
			assign src_low  = low_s[j-1];
			assign src_q    = q_s[j-1];
			assign src_d    = d_s[j-1];
			assign src_side = side_s[j-1];
		end

		always_comb begin
			for (int i = 0; i < 4; i++) begin
				cur[i] = {src_rem[i], src_low[i][Q-1-j]};
				ge[i]  = cur[i] >= {1'b0, src_d};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 4; i++) begin
					rem_s[j][i] <= ge[i] ? DW'(cur[i] - {1'b0, src_d}) : DW'(cur[i]);
					q_s[j][i]   <= {src_q[i][Q-2:0], ge[i]};
				end
				low_s[j]  <= src_low;
				d_s[j]    <= src_d;
				side_s[j] <= src_side;
			end
		end
	end

	assign out_vld  = vld_s[Q-1];
	assign out_r    = q_s[Q-1];
	assign out_side = side_s[Q-1];

endmodule

// ----- dv/quaternion_multiply_normalize_checker.sv -----
// Checker for the quaternion multiply-normalise unit: predicts each result word and compares.
`timescale 1ns / 1ps
module quaternion_multiply_normalize_checker #(
	parameter int FRAC_BITS = qmn_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,
	input  logic [0:0]   m_tuser,
	output int           errors,
	output int           pending,
	output int           degen_seen
);

	typedef struct {
		logic [3:0][15:0] p;
		logic             degen;
	} unit_quat_t;

	unit_quat_t expected_q[$];

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] clip16(input longint v);
		if (v > 32767) return 16'h7fff;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic string comp_name(input int i);
		case (i)
			0: return "p_w";
			1: return "p_x";
			2: return "p_y";
			default: return "p_z";
		endcase
	endfunction

	function automatic unit_quat_t normalised_product(input logic [127:0] d);
		unit_quat_t r;
		longint a[4], b[4], p[4];
		logic [63:0] mag[4], maxm, s, n, one, q;
		int rsh, lsh;
		for (int i = 0; i < 4; i++) begin
			a[i] = longint'($signed(d[16*i +: 16]));
			b[i] = longint'($signed(d[64 + 16*i +: 16]));
		end
		p[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
		p[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
		p[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
		p[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
		one = 64'd1 << FRAC_BITS;
		maxm = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = p[i] < 0 ? -p[i] : p[i];
			if (mag[i] > maxm) maxm = mag[i];
		end
		if (maxm == 0) begin
			r.p[0] = clip16(longint'(one));
			r.p[1] = 0;
			r.p[2] = 0;
			r.p[3] = 0;
			r.degen = 1'b1;
			return r;
		end
		rsh = 0;
		lsh = 0;
		while ((maxm >> rsh) >= (64'd1 << 30)) rsh++;
		while ((maxm << lsh) < (64'd1 << 29)) lsh++;
		s = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = (mag[i] >> rsh) << lsh;
			s = s + mag[i] * mag[i];
		end
		n = root64(s);
		for (int i = 0; i < 4; i++) begin
			q = (mag[i] * (one << 1) + n) / (n << 1);
			r.p[i] = clip16(p[i] < 0 ? -longint'(q) : longint'(q));
		end
		r.degen = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		unit_quat_t e;
		int bad;
		if (!arst_n) begin
			expected_q.delete();
			errors <= 0;
			pending <= 0;
			degen_seen <= 0;
		end else begin
			bad = 0;
			if (s_tvalid && s_tready) expected_q.push_back(normalised_product(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result word %h", m_tdata);
					bad++;
				end else begin
					e = expected_q.pop_front();
					if (e.degen) degen_seen <= degen_seen + 1;
					for (int i = 0; i < 4; i++) begin
						if (m_tdata[16*i +: 16] !== e.p[i]) begin
							$error("%s expected %h actual %h", comp_name(i), e.p[i],
								m_tdata[16*i +: 16]);
							bad++;
						end
					end
					if (m_tuser[0] !== e.degen) begin
						$error("degenerate expected %b actual %b", e.degen, m_tuser[0]);
						bad++;
					end
				end
			end
			errors <= errors + bad;
			pending <= expected_q.size();
		end
	end

endmodule

// ----- dv/quaternion_multiply_normalize_unit_test.sv -----
// Testbench top: drives quaternion pairs into the unit with random gaps and stalls.
`timescale 1ns / 1ps
module quaternion_multiply_normalize_unit_test;

	localparam int LATENCY = 40 + qmn_pkg::FRAC_BITS_DEF + 1;
	localparam longint LIMIT = 400000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;
	int           errors, pending, degen_seen;
	int           words_sent = 0;
	longint       cycles = 0;
	bit           long_hold = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	quaternion_multiply_normalize_unit u_top (.*);

	quaternion_multiply_normalize_checker u_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** quaternion_multiply_normalize_unit: FAILED **");
			$finish;
		end
	end

	function automatic logic [15:0] pick_comp();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'h4000;
			4: return 16'hc000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(input logic [127:0] d);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
		repeat (gap) @(negedge clk);
		s_tdata = d;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		words_sent++;
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		int wait_c;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready = 1'b0;
				repeat (300) @(negedge clk);
				long_hold = 1'b0;
			end
			wait_c = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
			m_tready = wait_c == 0;
			if (wait_c != 0) begin
				repeat (wait_c) @(negedge clk);
				m_tready = 1'b1;
			end
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		logic [127:0] d;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// directed: identity, zero product, extremes, each basis unit times the w and z units
		send_word({64'h0000_0000_0000_4000, 64'h0000_0000_0000_4000});
		send_word('0);
		send_word({64'h0, 64'h1234_5678_9abc_def0});
		send_word({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
		send_word({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
		send_word({64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001});
		send_word({64'hffff_ffff_ffff_ffff, 64'h0001_0001_0001_0001});
		send_word({64'hffff_0000_0000_0000, 64'hffff_0000_0000_0000});
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j += 3)
				send_word({64'h4000 << (16 * j), 64'h4000 << (16 * i)});
		send_word({64'h0001_0000_0000_0000, 64'h7fff_7fff_7fff_7fff});
		// long receiver hold-off while words keep coming
		long_hold = 1'b1;
		for (int k = 0; k < 80; k++) send_word({$urandom, $urandom, $urandom, $urandom});
		// sender pause until drained
		wait (pending == 0);
		for (int k = 0; k < 320; k++) begin
			for (int c = 0; c < 8; c++) d[16*c +: 16] = pick_comp();
			if ($urandom_range(0, 9) == 0) d[127:64] = '0;
			send_word(d);
		end
		wait (pending == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("sent %0d quaternion pairs, %0d gave the identity for a zero product",
			words_sent, degen_seen);
		$display("random gaps and stalls, one 300-cycle output hold-off, one drain pause");
		if (errors == 0) begin
			$display("** quaternion_multiply_normalize_unit: PASSED **");
		end else begin
			$display("** quaternion_multiply_normalize_unit: FAILED **");
		end
		$finish;
	end

endmodule
